### hw/rtl/tspb_pkg.sv
package tspb_pkg;

    localparam int CITY_COUNT_DEF = 256;
    localparam int DIST_BITS_DEF  = 32;

    localparam int CITY_BITS  = 8;
    localparam int EDGE_BITS  = 32;
    localparam int ROW_BITS   = 32;
    localparam int BOUND_BITS = 48;
    localparam int SUM_BITS   = 41;

    localparam logic signed [BOUND_BITS-1:0] BOUND_MAX = {1'b0, {(BOUND_BITS-1){1'b1}}};
    localparam logic signed [BOUND_BITS-1:0] BOUND_MIN = {1'b1, {(BOUND_BITS-1){1'b0}}};

    typedef enum logic
    {
        ACT_LOAD  = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

endpackage

### hw/rtl/tsp_two_min_edge_bound.sv
// Two-minimum-edge lower bound unit for a branch-and-bound tour search.
// Input channel (in_valid/in_ready) carries one transaction per item. With
// action set to load, one matrix element is taken, row by row; the element
// flagged with row_end closes the row, stores its two smallest values and
// produces one output transaction with the pair and the doubled initial bound.
// Loads without row_end produce no output. With action set to query, an edge
// and a parent bound are taken and one output transaction carries the child's
// doubled bound, saturated to 48 bits.
// Output channel (out_valid/out_ready) holds each result until taken.
// A result passes the middle stage and the output register. One transaction is
// accepted every cycle: the pair table is read at acceptance, and the bound
// arithmetic sits in the stage between that read and the output register.
// When the receiver stalls, the output register holds its result, one more
// result waits in the middle stage, and then in_ready falls.
// Reset clears the running minima to all ones and the running total to zero.
// The pair table needs no clearing; a row must be loaded before it is queried.
module tsp_two_min_edge_bound #(
    parameter int CITY_COUNT = tspb_pkg::CITY_COUNT_DEF,
    parameter int DIST_BITS  = tspb_pkg::DIST_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    action,
    input  logic [tspb_pkg::CITY_BITS-1:0]          from_city,
    input  logic [tspb_pkg::CITY_BITS-1:0]          to_city,
    input  logic [tspb_pkg::EDGE_BITS-1:0]          edge_distance,
    input  logic                                    row_end,
    input  logic signed [tspb_pkg::BOUND_BITS-1:0]  parent_bound_x2,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [tspb_pkg::ROW_BITS-1:0]           row_smallest,
    output logic [tspb_pkg::ROW_BITS-1:0]           row_second,
    output logic signed [tspb_pkg::BOUND_BITS-1:0]  bound_x2
);

    localparam int DW    = DIST_BITS;
    localparam int IDX_W = $clog2(CITY_COUNT);
    localparam int SW    = tspb_pkg::SUM_BITS;
    localparam int BW    = tspb_pkg::BOUND_BITS;
    localparam int ADD_W = ((DW + 1) > SW ? (DW + 1) : SW) + 1;
    localparam int VW    = (DW > (BW - 1) ? DW : (BW - 1)) + 4;
    localparam int ROW_PAD = tspb_pkg::ROW_BITS;

    localparam logic [ADD_W-1:0]      SUM_LIMIT = ADD_W'({SW{1'b1}});
    localparam logic signed [VW-1:0]  V_MAX     = VW'(tspb_pkg::BOUND_MAX);
    localparam logic signed [VW-1:0]  V_MIN     = VW'(tspb_pkg::BOUND_MIN);

    logic accept;
    logic is_load;
    logic s1_adv;

    logic [DW+tspb_pkg::EDGE_BITS-1:0] dist_ext;
    logic [DW-1:0]                     edge_dist;
    logic [DW-1:0]                     min_first_new;
    logic [DW-1:0]                     min_second_new;

    logic [IDX_W+tspb_pkg::CITY_BITS-1:0] from_ext;
    logic [IDX_W+tspb_pkg::CITY_BITS-1:0] to_ext;
    logic [IDX_W-1:0]                     from_idx;
    logic [IDX_W-1:0]                     to_idx;
    logic                                 from_ok;
    logic                                 to_ok;
    logic                                 tbl_wr_en;
    logic [2*DW-1:0]                      rd_from;
    logic [2*DW-1:0]                      rd_to;

    logic [DW-1:0] min_first_reg;
    logic [DW-1:0] min_first_next;
    logic [DW-1:0] min_second_reg;
    logic [DW-1:0] min_second_next;
    logic [SW-1:0] total_reg;
    logic [SW-1:0] total_next;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_load_reg;
    logic [DW-1:0]         s1_first_reg;
    logic [DW-1:0]         s1_second_reg;
    logic [DW-1:0]         s1_dist_reg;
    logic signed [BW-1:0]  s1_parent_reg;
    logic                  s1_from_ok_reg;
    logic                  s1_to_ok_reg;

    logic [ADD_W-1:0]      sum_wide;
    logic [SW-1:0]         sum_sat;
    logic [DW-1:0]         share_from;
    logic [DW-1:0]         share_to;
    logic signed [VW-1:0]  bound_wide;
    logic signed [BW-1:0]  bound_query;
    logic [DW+ROW_PAD-1:0] first_ext;
    logic [DW+ROW_PAD-1:0] second_ext;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [ROW_PAD-1:0]    row_smallest_reg;
    logic [ROW_PAD-1:0]    row_second_reg;
    logic signed [BW-1:0]  bound_reg;

    assign is_load  = (action == tspb_pkg::ACT_LOAD);
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    assign dist_ext  = {DW'(0), edge_distance};
    assign edge_dist = dist_ext[DW-1:0];

    always_comb
    begin
        min_first_new  = min_first_reg;
        min_second_new = min_second_reg;
        if (edge_dist < min_first_reg)
        begin
            min_first_new  = edge_dist;
            min_second_new = min_first_reg;
        end
        else if (edge_dist < min_second_reg)
        begin
            min_second_new = edge_dist;
        end
    end

    always_comb
    begin
        min_first_next  = min_first_reg;
        min_second_next = min_second_reg;
        if (accept && is_load)
        begin
            if (row_end)
            begin
                min_first_next  = '1;
                min_second_next = '1;
            end
            else
            begin
                min_first_next  = min_first_new;
                min_second_next = min_second_new;
            end
        end
    end

    assign from_ext  = {IDX_W'(0), from_city};
    assign to_ext    = {IDX_W'(0), to_city};
    assign from_idx  = from_ext[IDX_W-1:0];
    assign to_idx    = to_ext[IDX_W-1:0];
    assign from_ok   = (32'(from_city) < CITY_COUNT);
    assign to_ok     = (32'(to_city) < CITY_COUNT);
    assign tbl_wr_en = accept && is_load && row_end && from_ok;

    tspb_pair_table #(
        .DEPTH  (CITY_COUNT),
        .ADDR_W (IDX_W),
        .WORD_W (2 * DW)
    ) u_pair_table (
        .clk       (clk),
        .wr_en     (tbl_wr_en),
        .wr_addr   (from_idx),
        .wr_data   ({min_first_new, min_second_new}),
        .rd_en     (accept && !is_load),
        .rd_addr_a (from_idx),
        .rd_addr_b (to_idx),
        .rd_data_a (rd_from),
        .rd_data_b (rd_to)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept && (!is_load || row_end))
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Running total of row pairs, saturating at the top of its range.
    assign sum_wide = ADD_W'(total_reg) + ADD_W'(s1_first_reg) + ADD_W'(s1_second_reg);
    assign sum_sat  = (sum_wide > SUM_LIMIT) ? '1 : sum_wide[SW-1:0];

    always_comb
    begin
        total_next = total_reg;
        if (s1_adv && s1_load_reg)
        begin
            total_next = sum_sat;
        end
    end

    // Each end city gives its second smallest edge when the new edge reaches it, else its smallest; out of range, zero.
    always_comb
    begin
        share_from = '0;
        share_to   = '0;
        if (s1_from_ok_reg)
        begin
            share_from = (s1_dist_reg >= rd_from[DW-1:0]) ? rd_from[DW-1:0]
                                                          : rd_from[2*DW-1:DW];
        end
        if (s1_to_ok_reg)
        begin
            share_to = (s1_dist_reg >= rd_to[DW-1:0]) ? rd_to[DW-1:0]
                                                      : rd_to[2*DW-1:DW];
        end
    end

    assign bound_wide = VW'(s1_parent_reg) + $signed(VW'({s1_dist_reg, 1'b0}))
                      - $signed(VW'(share_from)) - $signed(VW'(share_to));

    always_comb
    begin
        if (bound_wide > V_MAX)
        begin
            bound_query = tspb_pkg::BOUND_MAX;
        end
        else if (bound_wide < V_MIN)
        begin
            bound_query = tspb_pkg::BOUND_MIN;
        end
        else
        begin
            bound_query = bound_wide[BW-1:0];
        end
    end

    assign first_ext  = {ROW_PAD'(0), s1_first_reg};
    assign second_ext = {ROW_PAD'(0), s1_second_reg};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_first_reg  <= '1;
            min_second_reg <= '1;
            total_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            min_first_reg  <= min_first_next;
            min_second_reg <= min_second_next;
            total_reg      <= total_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_load_reg    <= is_load;
            s1_first_reg   <= min_first_new;
            s1_second_reg  <= min_second_new;
            s1_dist_reg    <= edge_dist;
            s1_parent_reg  <= parent_bound_x2;
            s1_from_ok_reg <= from_ok;
            s1_to_ok_reg   <= to_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            if (s1_load_reg)
            begin
                row_smallest_reg <= first_ext[ROW_PAD-1:0];
                row_second_reg   <= second_ext[ROW_PAD-1:0];
                bound_reg        <= BW'(sum_sat);
            end
            else
            begin
                row_smallest_reg <= '0;
                row_second_reg   <= '0;
                bound_reg        <= bound_query;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign row_smallest = row_smallest_reg;
    assign row_second   = row_second_reg;
    assign bound_x2     = bound_reg;

endmodule

### hw/rtl/tspb_pair_table.sv
module tspb_pair_table #(
    parameter int DEPTH  = tspb_pkg::CITY_COUNT_DEF,
    parameter int ADDR_W = $clog2(tspb_pkg::CITY_COUNT_DEF),
    parameter int WORD_W = 2 * tspb_pkg::DIST_BITS_DEF
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WORD_W-1:0] rd_data_a,
    output logic [WORD_W-1:0] rd_data_b
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule
